// ===== src/rj_pkg.sv =====
`default_nettype none

package rj_pkg;

    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUDGE     = CFG_INDEX_WIDTH'(1);

    localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = CFG_WIDTH'(7);
    localparam logic [CFG_WIDTH-1:0] NUDGE_RESET     = CFG_WIDTH'(131);

endpackage

`default_nettype wire

// ===== src/rj_in_if.sv =====
`default_nettype none

interface rj_in_if #(
    parameter int WORD_WIDTH = rj_pkg::DEF_WORD_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] position_x;
    logic signed [WORD_WIDTH-1:0] position_y;
    logic signed [WORD_WIDTH-1:0] velocity_x;
    logic signed [WORD_WIDTH-1:0] velocity_y;

    modport source (
        output valid, position_x, position_y, velocity_x, velocity_y,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, velocity_x, velocity_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/rj_out_if.sv =====
`default_nettype none

interface rj_out_if #(
    parameter int WORD_WIDTH = rj_pkg::DEF_WORD_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] range_by_x;
    logic signed [WORD_WIDTH-1:0] range_by_y;
    logic signed [WORD_WIDTH-1:0] bearing_by_x;
    logic signed [WORD_WIDTH-1:0] bearing_by_y;
    logic signed [WORD_WIDTH-1:0] rate_by_x;
    logic signed [WORD_WIDTH-1:0] rate_by_y;
    logic                         saturated;

    modport source (
        output valid, range_by_x, range_by_y, bearing_by_x, bearing_by_y,
               rate_by_x, rate_by_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, range_by_x, range_by_y, bearing_by_x, bearing_by_y,
               rate_by_x, rate_by_y, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/radar_jacobian_top.sv =====
`default_nettype none

// Radar measurement Jacobian for one (px, py, vx, vy) state per beat, fixed
// point with FRAC_BITS fraction bits. Fully pipelined: one beat accepted per
// cycle while input ready is high. Between the accepted input beat and the
// output register lie the front stages, the bit-per-stage square root, the
// s*r and numerator multiplies and the six bit-per-stage dividers. A
// two-entry output register/skid keeps input ready high while one result
// waits. Once the skid entry fills, input ready drops and the whole pipe
// holds. Input ready comes back as the skid entry moves to the output.
// Tiny squared range nudges both positions; zero range gives all-zero
// entries. Write configuration only while the pipe is empty.
module radar_jacobian_top #(
    parameter int WORD_WIDTH = rj_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = rj_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rj_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [rj_pkg::CFG_WIDTH-1:0]         i_cfg_data,
    rj_in_if.sink                                     i_item,
    rj_out_if.source                                  o_result
);
    import rj_pkg::*;

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = ((W > 17) ? W : 17) + 1;
    localparam int MW  = PW - 1;
    localparam int SW  = 2 * MW + 1;
    localparam int RW  = MW + 1;
    localparam int DMW = W + PW;
    localparam int N0W = MW + F;
    localparam int N2W = MW + 2 * F;
    localparam int N4W = MW + DMW + F;
    localparam int D3W = SW + RW;
    localparam int DL  = W + 2;
    localparam int LAT = 9 + RW + 2 + DL;
    localparam int TW  = ((SW - F) > CFG_WIDTH) ? (SW - F) : CFG_WIDTH;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pxn;
        logic signed [PW-1:0] pyn;
        logic        [MW-1:0] mx;
        logic        [MW-1:0] my;
        logic        [MW-1:0] mxn;
        logic        [MW-1:0] myn;
        logic signed [W-1:0]  vx;
        logic signed [W-1:0]  vy;
    } t_front;

    typedef struct packed {
        logic        [SW-1:0] s;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic        [MW-1:0] mx;
        logic        [MW-1:0] my;
        logic signed [W-1:0]  vx;
        logic signed [W-1:0]  vy;
    } t_sel;

    typedef struct packed {
        logic [SW-1:0] s;
        logic          sx;
        logic          sy;
        logic [MW-1:0] mx;
        logic [MW-1:0] my;
    } t_geo;

    typedef struct packed {
        t_geo           g;
        logic [DMW-1:0] dmag;
        logic           dneg;
    } t_mid;

    typedef struct packed {
        t_geo          g;
        logic [RW-1:0] r;
        logic          dneg;
    } t_pre;

    typedef struct packed {
        logic signed [W-1:0] range_by_x;
        logic signed [W-1:0] range_by_y;
        logic signed [W-1:0] bearing_by_x;
        logic signed [W-1:0] bearing_by_y;
        logic signed [W-1:0] rate_by_x;
        logic signed [W-1:0] rate_by_y;
        logic                saturated;
    } t_res;

    // configuration
    logic [CFG_WIDTH-1:0] r_thr;
    logic [CFG_WIDTH-1:0] r_nudge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RESET;
            r_nudge <= NUDGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_thr   <= i_cfg_data;
                REG_NUDGE:     r_nudge <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // pipeline enable: stops only when the skid entry is occupied
    logic             en;
    logic             r_skid_full;
    logic [LAT-1:0]   r_vld;

    assign en           = !r_skid_full;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_item.valid};
        end
    end

    // S1: widen, nudged copies
    logic signed [PW-1:0] px_ext, py_ext, nudge_ext;
    logic signed [PW-1:0] r1_px, r1_py, r1_pxn, r1_pyn;
    logic signed [W-1:0]  r1_vx, r1_vy;

    assign px_ext    = {{(PW-W){i_item.position_x[W-1]}}, i_item.position_x};
    assign py_ext    = {{(PW-W){i_item.position_y[W-1]}}, i_item.position_y};
    assign nudge_ext = $signed({{(PW-CFG_WIDTH){1'b0}}, r_nudge});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px  <= px_ext;
            r1_py  <= py_ext;
            r1_pxn <= px_ext + nudge_ext;
            r1_pyn <= py_ext + nudge_ext;
            r1_vx  <= i_item.velocity_x;
            r1_vy  <= i_item.velocity_y;
        end
    end

    // S2: magnitudes
    logic [PW-1:0] neg_px, neg_py, neg_pxn, neg_pyn;
    t_front        r2, r3, r4;

    assign neg_px  = -r1_px;
    assign neg_py  = -r1_py;
    assign neg_pxn = -r1_pxn;
    assign neg_pyn = -r1_pyn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2.px  <= r1_px;
            r2.py  <= r1_py;
            r2.pxn <= r1_pxn;
            r2.pyn <= r1_pyn;
            r2.mx  <= r1_px[PW-1]  ? neg_px[MW-1:0]  : r1_px[MW-1:0];
            r2.my  <= r1_py[PW-1]  ? neg_py[MW-1:0]  : r1_py[MW-1:0];
            r2.mxn <= r1_pxn[PW-1] ? neg_pxn[MW-1:0] : r1_pxn[MW-1:0];
            r2.myn <= r1_pyn[PW-1] ? neg_pyn[MW-1:0] : r1_pyn[MW-1:0];
            r2.vx  <= r1_vx;
            r2.vy  <= r1_vy;
            r3     <= r2;
            r4     <= r3;
        end
    end

    // S3-S4: squares of plain and nudged positions
    logic [2*MW-1:0] sq_x, sq_y, sq_xn, sq_yn;

    rj_mul #(.AW(MW), .BW(MW)) u_sq_x  (.i_clk, .i_en(en), .i_a(r2.mx),  .i_b(r2.mx),
                                        .o_p(sq_x));
    rj_mul #(.AW(MW), .BW(MW)) u_sq_y  (.i_clk, .i_en(en), .i_a(r2.my),  .i_b(r2.my),
                                        .o_p(sq_y));
    rj_mul #(.AW(MW), .BW(MW)) u_sq_xn (.i_clk, .i_en(en), .i_a(r2.mxn), .i_b(r2.mxn),
                                        .o_p(sq_xn));
    rj_mul #(.AW(MW), .BW(MW)) u_sq_yn (.i_clk, .i_en(en), .i_a(r2.myn), .i_b(r2.myn),
                                        .o_p(sq_yn));

    // S5: sums; S6: pick plain or nudged
    logic [SW-1:0] r5_s0, r5_s1;
    t_front        r5;
    t_sel          r6;
    logic          tiny;

    assign tiny = TW'(r5_s0[SW-1:F]) < TW'(r_thr);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_s0 <= SW'(sq_x) + SW'(sq_y);
            r5_s1 <= SW'(sq_xn) + SW'(sq_yn);
            r5    <= r4;
            r6.s  <= tiny ? r5_s1  : r5_s0;
            r6.px <= tiny ? r5.pxn : r5.px;
            r6.py <= tiny ? r5.pyn : r5.py;
            r6.mx <= tiny ? r5.mxn : r5.mx;
            r6.my <= tiny ? r5.myn : r5.my;
            r6.vx <= r5.vx;
            r6.vy <= r5.vy;
        end
    end

    // S7-S9: vx*py - vy*px as sign and magnitude
    logic signed [W+PW-1:0] r7_a, r7_b;
    logic signed [W+PW:0]   r8_d;
    logic        [W+PW:0]   neg_d;
    t_geo                   r7_g, r8_g, r9_g;
    logic [DMW-1:0]         r9_dmag;
    logic                   r9_dneg;

    assign neg_d = -r8_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_a    <= $signed(r6.vx) * $signed(r6.py);
            r7_b    <= $signed(r6.vy) * $signed(r6.px);
            r7_g.s  <= r6.s;
            r7_g.sx <= r6.px[PW-1];
            r7_g.sy <= r6.py[PW-1];
            r7_g.mx <= r6.mx;
            r7_g.my <= r6.my;
            r8_d    <= (W+PW+1)'(r7_a) - (W+PW+1)'(r7_b);
            r8_g    <= r7_g;
            r9_dneg <= r8_d[W+PW];
            r9_dmag <= r8_d[W+PW] ? neg_d[DMW-1:0] : r8_d[DMW-1:0];
            r9_g    <= r8_g;
        end
    end

    // square root, side data shifted alongside
    logic [RW-1:0] root;
    t_mid          r_mid [RW];

    rj_sqrt #(.RW(RW)) u_sqrt (
        .i_clk,
        .i_en   (en),
        .i_val  ({1'b0, r9_g.s}),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid[0] <= '{g: r9_g, dmag: r9_dmag, dneg: r9_dneg};
            for (int k = 1; k < RW; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    // s*r and the two rate numerators
    logic [D3W-1:0]    den3;
    logic [MW+DMW-1:0] num4, num5;
    t_pre              r_pre [2];

    rj_mul #(.AW(RW), .BW(SW)) u_den3 (
        .i_clk, .i_en(en), .i_a(root), .i_b(r_mid[RW-1].g.s), .o_p(den3)
    );
    rj_mul #(.AW(MW), .BW(DMW)) u_num4 (
        .i_clk, .i_en(en), .i_a(r_mid[RW-1].g.my), .i_b(r_mid[RW-1].dmag), .o_p(num4)
    );
    rj_mul #(.AW(MW), .BW(DMW)) u_num5 (
        .i_clk, .i_en(en), .i_a(r_mid[RW-1].g.mx), .i_b(r_mid[RW-1].dmag), .o_p(num5)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre[0] <= '{g: r_mid[RW-1].g, r: root, dneg: r_mid[RW-1].dneg};
            r_pre[1] <= r_pre[0];
        end
    end

    // six dividers
    t_pre                p;
    logic signed [W-1:0] q [6];
    logic [5:0]          clip;
    logic [DL-1:0]       r_zero;

    assign p = r_pre[1];

    rj_div #(.W(W), .NW(N0W), .DW(RW)) u_div0 (
        .i_clk, .i_en(en), .i_num({p.g.mx, {F{1'b0}}}), .i_den(p.r),
        .i_neg(p.g.sx), .o_q(q[0]), .o_clip(clip[0])
    );
    rj_div #(.W(W), .NW(N0W), .DW(RW)) u_div1 (
        .i_clk, .i_en(en), .i_num({p.g.my, {F{1'b0}}}), .i_den(p.r),
        .i_neg(p.g.sy), .o_q(q[1]), .o_clip(clip[1])
    );
    rj_div #(.W(W), .NW(N2W), .DW(SW)) u_div2 (
        .i_clk, .i_en(en), .i_num({p.g.my, {(2*F){1'b0}}}), .i_den(p.g.s),
        .i_neg(!p.g.sy), .o_q(q[2]), .o_clip(clip[2])
    );
    rj_div #(.W(W), .NW(N2W), .DW(SW)) u_div3 (
        .i_clk, .i_en(en), .i_num({p.g.mx, {(2*F){1'b0}}}), .i_den(p.g.s),
        .i_neg(p.g.sx), .o_q(q[3]), .o_clip(clip[3])
    );
    rj_div #(.W(W), .NW(N4W), .DW(D3W)) u_div4 (
        .i_clk, .i_en(en), .i_num({num4, {F{1'b0}}}), .i_den(den3),
        .i_neg(p.g.sy != p.dneg), .o_q(q[4]), .o_clip(clip[4])
    );
    rj_div #(.W(W), .NW(N4W), .DW(D3W)) u_div5 (
        .i_clk, .i_en(en), .i_num({num5, {F{1'b0}}}), .i_den(den3),
        .i_neg(p.g.sx == p.dneg), .o_q(q[5]), .o_clip(clip[5])
    );

    // zero range marker follows the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= {r_zero[DL-2:0], (p.r == '0)};
        end
    end

    // last pipeline beat
    t_res data_p;
    logic vld_p;
    logic zero_p;

    assign vld_p  = r_vld[LAT-1];
    assign zero_p = r_zero[DL-1];

    always_comb begin
        data_p.range_by_x   = zero_p ? '0 : q[0];
        data_p.range_by_y   = zero_p ? '0 : q[1];
        data_p.bearing_by_x = zero_p ? '0 : q[2];
        data_p.bearing_by_y = zero_p ? '0 : q[3];
        data_p.rate_by_x    = zero_p ? '0 : q[4];
        data_p.rate_by_y    = zero_p ? '0 : q[5];
        data_p.saturated    = !zero_p && (|clip);
    end

    // output register plus skid entry
    t_res r_out, r_skid;
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (r_out_vld && !o_result.ready) begin
                if (en && vld_p) begin
                    r_skid      <= data_p;
                    r_skid_full <= 1'b1;
                end
            end else if (r_skid_full) begin
                r_out       <= r_skid;
                r_out_vld   <= 1'b1;
                r_skid_full <= 1'b0;
            end else begin
                r_out     <= data_p;
                r_out_vld <= en && vld_p;
            end
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.range_by_x   = r_out.range_by_x;
    assign o_result.range_by_y   = r_out.range_by_y;
    assign o_result.bearing_by_x = r_out.bearing_by_x;
    assign o_result.bearing_by_y = r_out.bearing_by_y;
    assign o_result.rate_by_x    = r_out.rate_by_x;
    assign o_result.rate_by_y    = r_out.rate_by_y;
    assign o_result.saturated    = r_out.saturated;

endmodule

`default_nettype wire

// ===== src/rj_mul.sv =====
`default_nettype none

// unsigned multiply, b split in two halves, two stages
module rj_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output      logic [AW+BW-1:0] o_p
);
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;

    logic [AW+BL-1:0] r_lo;
    logic [AW+BH-1:0] r_hi;
    logic [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= i_a * i_b[BL-1:0];
            r_hi <= i_a * i_b[BW-1:BL];
            r_p  <= ((AW+BW)'(r_hi) << BL) + (AW+BW)'(r_lo);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== src/rj_sqrt.sv =====
`default_nettype none

// floor square root, one root bit per stage
module rj_sqrt #(
    parameter int RW = 33
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [2*RW-1:0] i_val,
    output      logic [RW-1:0]   o_root
);
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_val  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   p_rem;
        logic [RW-1:0]   p_root;
        logic [2*RW-1:0] p_val;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_val;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_val  = r_val[k-1];
        end

        assign cur   = {p_rem, p_val[2*RW-1 -: 2]};
        assign trial = (RW+4)'({p_root, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
                r_root[k] <= {p_root[RW-2:0], ge};
                r_val[k]  <= p_val << 2;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

// ===== src/rj_div.sv =====
`default_nettype none

// truncating divide of magnitudes, W quotient bits, one per stage,
// then sign and clip to a W-bit signed word
module rj_div #(
    parameter int W  = 32,
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [NW-1:0]       i_num,
    input  wire logic [DW-1:0]       i_den,
    input  wire logic                i_neg,
    output      logic signed [W-1:0] o_q,
    output      logic                o_clip
);
    localparam int HW = NW - W;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] r_rem [W+1];
    logic [W-1:0]  r_q   [W+1];
    logic [W-1:0]  r_low [W+1];
    logic [DW-1:0] r_den [W+1];
    logic          r_neg [W+1];
    logic          r_ovf [W+1];

    logic          ovf;
    logic [W-1:0]  lim;
    logic          clip;
    logic [W-1:0]  qmag;
    logic signed [W-1:0] r_q_out;
    logic          r_clip;

    // quotient of 2^W or more always clips
    assign ovf = CW'(i_num[NW-1:W]) >= CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= ovf ? '0 : DW'(i_num[NW-1:W]);
            r_q[0]   <= '0;
            r_low[0] <= i_num[W-1:0];
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= ovf;
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_stage
        logic [DW:0] t;
        logic        ge;

        assign t  = {r_rem[j-1], r_low[j-1][W-1]};
        assign ge = t >= {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? DW'(t - {1'b0, r_den[j-1]}) : DW'(t);
                r_q[j]   <= {r_q[j-1][W-2:0], ge};
                r_low[j] <= r_low[j-1] << 1;
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign lim  = r_neg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign clip = r_ovf[W] || (r_q[W] > lim);
    assign qmag = clip ? lim : r_q[W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_out <= r_neg[W] ? $signed(-qmag) : $signed(qmag);
            r_clip  <= clip;
        end
    end

    assign o_q    = r_q_out;
    assign o_clip = r_clip;

endmodule

`default_nettype wire

// ===== tb/sv/radar_jacobian_top_tb.sv =====
`timescale 1ns / 1ps

module radar_jacobian_top_tb;
    import rj_pkg::*;

    localparam int W = DEF_WORD_WIDTH;
    localparam int F = DEF_FRAC_BITS;
    localparam int STALL_LIMIT = 6000;
    localparam int PIPE_DRAIN = 120;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
    } track_state_t;

    typedef struct packed {
        logic [W-1:0] range_by_x;
        logic [W-1:0] range_by_y;
        logic [W-1:0] bearing_by_x;
        logic [W-1:0] bearing_by_y;
        logic [W-1:0] rate_by_x;
        logic [W-1:0] rate_by_y;
        logic         saturated;
    } jacobian_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0] i_cfg_data;

    rj_in_if  #(.WORD_WIDTH(W)) track_bus ();
    rj_out_if #(.WORD_WIDTH(W)) jacobian_bus ();

    radar_jacobian_top #(.WORD_WIDTH(W), .FRAC_BITS(F)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (track_bus),
        .o_result   (jacobian_bus)
    );

    logic [15:0] range_floor;
    logic [15:0] nudge_step;
    jacobian_t pending_jacobians[$];
    int errors = 0;
    int idle_cycles = 0;
    int holdoff_cycles = 0;
    bit jitter_on = 1;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] magnitude(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos >>= 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v -= root + bitpos;
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    // truncating quotient of magnitudes, then sign and clip to the word
    function automatic logic [W-1:0] clipped_quotient(logic [127:0] num, logic [127:0] den,
                                                      bit neg, inout bit clip);
        logic [127:0] q;
        logic [127:0] lim;
        q = num / den;
        lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
        if (q > lim) begin
            clip = 1;
            q = lim;
        end
        return neg ? W'(-q) : W'(q);
    endfunction

    function automatic jacobian_t jacobian_of(track_state_t t);
        jacobian_t j;
        longint px, py, vx, vy, a, b;
        logic [63:0] s, r, dmag;
        logic [127:0] den3;
        bit dneg, clip;
        px = t.px; py = t.py; vx = t.vx; vy = t.vy;
        clip = 0;
        j = '0;
        s = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py);
        if ((s >> F) < range_floor) begin
            px += nudge_step;
            py += nudge_step;
            s = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py);
        end
        r = floor_sqrt(s);
        if (r == 0) return j;
        den3 = 128'(s) * 128'(r);
        j.range_by_x = clipped_quotient(128'(magnitude(px)) << F, 128'(r), px < 0, clip);
        j.range_by_y = clipped_quotient(128'(magnitude(py)) << F, 128'(r), py < 0, clip);
        j.bearing_by_x = clipped_quotient(128'(magnitude(py)) << (2 * F), 128'(s), py > 0, clip);
        j.bearing_by_y = clipped_quotient(128'(magnitude(px)) << (2 * F), 128'(s), px < 0, clip);
        a = vx * py;
        b = vy * px;
        if (a >= b) begin
            dmag = 64'(a) - 64'(b);
            dneg = 0;
        end else begin
            dmag = 64'(b) - 64'(a);
            dneg = 1;
        end
        j.rate_by_x = clipped_quotient((128'(magnitude(py)) * 128'(dmag)) << F, den3,
                                       (py < 0) != dneg, clip);
        j.rate_by_y = clipped_quotient((128'(magnitude(px)) * 128'(dmag)) << F, den3,
                                       (px < 0) == dneg, clip);
        j.saturated = clip;
        return j;
    endfunction

    // result side: random ready, long hold-off on request, check each beat
    always @(posedge i_clk) begin
        jacobian_t got, want;
        if (i_rst_n && jacobian_bus.valid && jacobian_bus.ready) begin
            got.range_by_x = jacobian_bus.range_by_x;
            got.range_by_y = jacobian_bus.range_by_y;
            got.bearing_by_x = jacobian_bus.bearing_by_x;
            got.bearing_by_y = jacobian_bus.bearing_by_y;
            got.rate_by_x = jacobian_bus.rate_by_x;
            got.rate_by_y = jacobian_bus.rate_by_y;
            got.saturated = jacobian_bus.saturated;
            if (pending_jacobians.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: actual %h", $time, got);
            end else begin
                want = pending_jacobians.pop_front();
                if (got.range_by_x !== want.range_by_x) begin
                    errors++;
                    $display("%0t range_by_x exp %h act %h", $time, want.range_by_x,
                             got.range_by_x);
                end
                if (got.range_by_y !== want.range_by_y) begin
                    errors++;
                    $display("%0t range_by_y exp %h act %h", $time, want.range_by_y,
                             got.range_by_y);
                end
                if (got.bearing_by_x !== want.bearing_by_x) begin
                    errors++;
                    $display("%0t bearing_by_x exp %h act %h", $time, want.bearing_by_x,
                             got.bearing_by_x);
                end
                if (got.bearing_by_y !== want.bearing_by_y) begin
                    errors++;
                    $display("%0t bearing_by_y exp %h act %h", $time, want.bearing_by_y,
                             got.bearing_by_y);
                end
                if (got.rate_by_x !== want.rate_by_x) begin
                    errors++;
                    $display("%0t rate_by_x exp %h act %h", $time, want.rate_by_x,
                             got.rate_by_x);
                end
                if (got.rate_by_y !== want.rate_by_y) begin
                    errors++;
                    $display("%0t rate_by_y exp %h act %h", $time, want.rate_by_y,
                             got.rate_by_y);
                end
                if (got.saturated !== want.saturated) begin
                    errors++;
                    $display("%0t saturated exp %b act %b", $time, want.saturated,
                             got.saturated);
                end
            end
        end
        if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            jacobian_bus.ready <= 1'b0;
        end else begin
            jacobian_bus.ready <= !(jitter_on && $urandom_range(99) < 16);
        end
    end

    always @(posedge i_clk) begin
        if ((track_bus.valid && track_bus.ready) || (jacobian_bus.valid && jacobian_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_track(track_state_t t);
        int gap;
        if (jitter_on && $urandom_range(99) < 16) begin
            gap = $urandom_range(1, 4);
            track_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        track_bus.valid <= 1'b1;
        track_bus.position_x <= t.px;
        track_bus.position_y <= t.py;
        track_bus.velocity_x <= t.vx;
        track_bus.velocity_y <= t.vy;
        do @(posedge i_clk); while (!track_bus.ready);
        pending_jacobians.push_back(jacobian_of(t));
    endtask

    task automatic drain_pipe();
        track_bus.valid <= 1'b0;
        while (pending_jacobians.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD) range_floor = val;
        else if (idx == REG_NUDGE) nudge_step = val;
    endtask

    function automatic logic [W-1:0] random_word(int kind);
        case (kind)
            0: return W'($urandom);
            1: return W'($signed($urandom_range(0, 1023)) - 512);
            2: return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return W'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic track_state_t random_track();
        track_state_t t;
        int kind;
        kind = $urandom_range(3);
        t.px = random_word(kind);
        t.py = random_word($urandom_range(9) < 7 ? kind : $urandom_range(3));
        t.vx = random_word($urandom_range(3));
        t.vy = random_word($urandom_range(3));
        return t;
    endfunction

    task automatic test_directed();
        logic signed [W-1:0] edges[8];
        edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh0001_0000, -32'sh0001_0000, 5};
        send_track('{0, 0, 0, 0});
        send_track('{1, 0, 32'sh7fff_ffff, 32'sh8000_0000});
        send_track('{0, 1, 32'sh8000_0000, 32'sh7fff_ffff});
        send_track('{-131, -131, 3, -3});
        send_track('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_track('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
        send_track('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
        send_track('{2, -2, 32'sh0001_0000, 0});
        for (int k = 0; k < 12; k++)
            send_track('{edges[$urandom_range(7)], edges[$urandom_range(7)],
                         edges[$urandom_range(7)], edges[$urandom_range(7)]});
        drain_pipe();
    endtask

    // range floor / nudge at their extremes, with small positions
    task automatic test_register_extremes();
        logic [15:0] floors[3] = '{16'd0, 16'hffff, 16'd0};
        logic [15:0] nudges[3] = '{16'd0, 16'd0, 16'hffff};
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_THRESHOLD, floors[p]);
            write_reg(REG_NUDGE, nudges[p]);
            send_track('{0, 0, 1, 1});
            send_track('{1, 0, -1, 1});
            send_track('{-255, 255, 32'sh7fff_ffff, 0});
            for (int k = 0; k < 60; k++)
                send_track('{random_word(1), random_word(1), random_word(0), random_word(2)});
            drain_pipe();
        end
    endtask

    task automatic test_random_stream(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 300 == 0) begin
                drain_pipe();
                write_reg(REG_THRESHOLD, 16'($urandom));
                write_reg(REG_NUDGE, 16'($urandom_range(0, 600)));
            end
            send_track(random_track());
        end
        drain_pipe();
    endtask

    task automatic test_backpressure();
        holdoff_cycles = 400;
        for (int k = 0; k < 150; k++) send_track(random_track());
        drain_pipe();
    endtask

    task automatic test_back_to_back();
        jitter_on = 0;
        for (int k = 0; k < 150; k++) send_track(random_track());
        jitter_on = 1;
        drain_pipe();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        track_bus.valid <= 1'b0;
        track_bus.position_x <= '0;
        track_bus.position_y <= '0;
        track_bus.velocity_x <= '0;
        track_bus.velocity_y <= '0;
        range_floor = THRESHOLD_RESET;
        nudge_step = NUDGE_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_stream(400);
        test_register_extremes();
        test_back_to_back();
        test_backpressure();
        test_random_stream(750);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
